### rtl/run_request_wakeup_validation_manager_core_macros.svh
// assertion macros for the run request and wakeup validation manager
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef RUN_REQUEST_WAKEUP_VALIDATION_MANAGER_CORE_MACROS_SVH
`define RUN_REQUEST_WAKEUP_VALIDATION_MANAGER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RRWVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RRWVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  `RRWVM_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define RRWVM_ASSERT(lbl, prop, msg)
`define RRWVM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/rrwvm_pkg.sv
// types, codes and default sizes of the run request and wakeup validation manager
// no dependencies
package rrwvm_pkg;

  localparam int unsigned DEF_SOURCES    = 16;
  localparam int unsigned DEF_USERS      = 16;
  localparam int unsigned DEF_TIMER_BITS = 16;

  localparam int unsigned MASK_W = 16;

  localparam logic [15:0] TICKS_RESET = 16'd10;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_SET     = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_REQUEST = 3'd3,
    OP_RELEASE = 3'd4,
    OP_KILL    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    CFG_ENABLED = 2'd0,
    CFG_TICKS   = 2'd1,
    CFG_TARGET  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TGT_SLEEP = 2'd0,
    TGT_OFF   = 2'd1,
    TGT_RESET = 2'd2
  } target_e;

  typedef enum logic [1:0] {
    ECU_RUN   = 2'd0,
    ECU_POST  = 2'd1,
    ECU_SLEEP = 2'd2,
    ECU_SHUT  = 2'd3
  } ecu_mode_e;

  typedef enum logic [3:0] {
    MODE_RUN   = 4'b0001,
    MODE_POST  = 4'b0010,
    MODE_SLEEP = 4'b0100,
    MODE_SHUT  = 4'b1000
  } mode_e;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_PENDING = 2'd1,
    ST_VALID   = 2'd2,
    ST_EXPIRED = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [MASK_W-1:0] source_mask;
    logic [4:0]        user_id;
    logic [3:0]        query_source;
  } req_t;

  typedef struct packed {
    logic [1:0]        ecu_mode;
    logic [MASK_W-1:0] pending_out;
    logic [MASK_W-1:0] validated_out;
    logic [MASK_W-1:0] expired_out;
    logic [MASK_W-1:0] requests_out;
    logic [MASK_W-1:0] killed_out;
    logic [1:0]        query_status;
    logic              bad_user;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] wdata;
  } cfg_t;

endpackage

### rtl/rrwvm_chan_if.sv
// valid/ready channel carrying one payload per transfer
// payload type is given by the instantiating code, usually from rrwvm_pkg
interface rrwvm_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/run_request_wakeup_validation_manager_core.sv
// top level of the run request and wakeup validation manager
// uses rrwvm_pkg, rrwvm_chan_if and the assertion macro header
//
// One event per transfer on req_i gives one result on rsp_o. An accepted event
// sits in an input register, where the whole state update (mode, masks, every
// source status and timer in parallel) is done, and the result is written to
// the output register as the event leaves the input register, so a new event
// can be accepted every cycle while rsp_o is taken. The rate is one event per
// cycle as long as rsp_o is taken; a stalled result holds the input register
// and then req_i. cfg_i is always ready; registers must only be written while
// no event is in flight.
`include "run_request_wakeup_validation_manager_core_macros.svh"

module run_request_wakeup_validation_manager_core
  import rrwvm_pkg::*;
#(
  parameter int unsigned SOURCES    = DEF_SOURCES,
  parameter int unsigned USERS      = DEF_USERS,
  parameter int unsigned TIMER_BITS = DEF_TIMER_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rrwvm_chan_if.sink   req_i,
  rrwvm_chan_if.source rsp_o,
  rrwvm_chan_if.sink   cfg_i
);

  // configuration
  logic [15:0] enabled_q;
  logic [15:0] ticks_q;
  logic [1:0]  target_q;

  // pipeline
  logic in_vld_q, in_vld_d;
  req_t in_q;
  logic out_vld_q, out_vld_d;
  rsp_t out_q, out_d;
  logic adv;

  // architectural state
  mode_e                 mode_q, mode_d;
  logic [USERS-1:0]      run_q, run_d;
  logic [USERS-1:0]      killed_q, killed_d;
  logic [SOURCES-1:0]    pend_q, pend_d;
  logic [SOURCES-1:0]    val_q, val_d;
  logic [SOURCES-1:0]    exp_q, exp_d;
  status_e               status_q [SOURCES];
  status_e               status_d [SOURCES];
  logic [TIMER_BITS-1:0] timer_q [SOURCES];
  logic [TIMER_BITS-1:0] timer_d [SOURCES];

  logic [SOURCES-1:0]    src_mask;
  logic [SOURCES-1:0]    set_mask;
  logic [USERS-1:0]      user_oh;
  logic                  bad;
  logic [TIMER_BITS-1:0] load_val;
  logic [TIMER_BITS-1:0] timer_dec;
  logic [1:0]            query;
  logic [1:0]            mode_code;
  logic                  timer_ok;

  assign adv         = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || adv;
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  assign src_mask = SOURCES'(in_q.source_mask);
  assign set_mask = src_mask & SOURCES'(enabled_q);
  assign load_val = TIMER_BITS'(ticks_q);
  assign bad      = int'(in_q.user_id) >= USERS;

  always_comb begin
    for (int u = 0; u < USERS; u++) begin
      user_oh[u] = (int'(in_q.user_id) == u);
    end
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (req_i.valid && req_i.ready) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // next state for the event in the input register
  always_comb begin
    mode_d   = mode_q;
    run_d    = run_q;
    killed_d = killed_q;
    pend_d   = pend_q;
    val_d    = val_q;
    exp_d    = exp_q;
    timer_dec = '0;
    for (int i = 0; i < SOURCES; i++) begin
      status_d[i] = status_q[i];
      timer_d[i]  = timer_q[i];
    end

    case (in_q.opcode)
      OP_TICK: begin
        case (mode_q)
          MODE_RUN: begin
            if (run_q == '0) begin
              mode_d = MODE_POST;
            end
          end
          MODE_POST: begin
            if (target_q == TGT_SLEEP) begin
              mode_d = MODE_SLEEP;
            end else if (target_q == TGT_OFF || target_q == TGT_RESET) begin
              mode_d = MODE_SHUT;
            end
          end
          MODE_SLEEP: begin
            if (pend_q != '0) begin
              mode_d = MODE_RUN;
            end
          end
          default: begin
            mode_d = mode_q;
          end
        endcase
        for (int i = 0; i < SOURCES; i++) begin
          timer_dec = timer_q[i] - 1'b1;
          if (status_q[i] == ST_PENDING) begin
            if (timer_q[i] != '0) begin
              timer_d[i] = timer_dec;
              if (timer_dec == '0) begin
                status_d[i] = ST_VALID;
                pend_d[i]   = 1'b0;
                val_d[i]    = 1'b1;
              end
            end else begin
              // pending with an empty timer times out
              status_d[i] = ST_EXPIRED;
              pend_d[i]   = 1'b0;
              exp_d[i]    = 1'b1;
            end
          end
        end
      end
      OP_SET: begin
        pend_d = pend_q | set_mask;
        for (int i = 0; i < SOURCES; i++) begin
          if (set_mask[i] && status_q[i] == ST_NONE) begin
            status_d[i] = ST_PENDING;
            timer_d[i]  = load_val;
          end
        end
      end
      OP_CLEAR: begin
        pend_d = pend_q & ~src_mask;
        val_d  = val_q & ~src_mask;
        exp_d  = exp_q & ~src_mask;
        for (int i = 0; i < SOURCES; i++) begin
          if (src_mask[i]) begin
            status_d[i] = ST_NONE;
            timer_d[i]  = '0;
          end
        end
      end
      OP_REQUEST: begin
        if (!bad) begin
          run_d = run_q | user_oh;
          if (mode_q == MODE_POST) begin
            mode_d = MODE_RUN;
          end
        end
      end
      OP_RELEASE: begin
        if (!bad) begin
          run_d = run_q & ~user_oh;
          if (run_d == '0 && mode_q == MODE_RUN) begin
            mode_d = MODE_POST;
          end
        end
      end
      OP_KILL: begin
        killed_d = run_q;
        run_d    = '0;
        if (mode_q == MODE_RUN) begin
          mode_d = MODE_POST;
        end
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
  end

  always_comb begin
    query = ST_NONE;
    for (int i = 0; i < SOURCES; i++) begin
      if (int'(in_q.query_source) == i) begin
        query = status_d[i];
      end
    end
  end

  always_comb begin
    case (mode_d)
      MODE_RUN:   mode_code = ECU_RUN;
      MODE_POST:  mode_code = ECU_POST;
      MODE_SLEEP: mode_code = ECU_SLEEP;
      MODE_SHUT:  mode_code = ECU_SHUT;
      default:    mode_code = ECU_RUN;
    endcase
  end

  always_comb begin
    out_d.ecu_mode      = mode_code;
    out_d.pending_out   = MASK_W'(pend_d);
    out_d.validated_out = MASK_W'(val_d);
    out_d.expired_out   = MASK_W'(exp_d);
    out_d.requests_out  = MASK_W'(run_d);
    out_d.killed_out    = MASK_W'(killed_d);
    out_d.query_status  = query;
    out_d.bad_user      = bad && (in_q.opcode == OP_REQUEST || in_q.opcode == OP_RELEASE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= '0;
      ticks_q   <= TICKS_RESET;
      target_q  <= TGT_SLEEP;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.data.index)
        CFG_ENABLED: enabled_q <= cfg_i.data.wdata;
        CFG_TICKS:   ticks_q   <= cfg_i.data.wdata;
        CFG_TARGET:  target_q  <= cfg_i.data.wdata[1:0];
        default:     enabled_q <= enabled_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= req_i.data;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_RUN;
      run_q    <= '0;
      killed_q <= '0;
      pend_q   <= '0;
      val_q    <= '0;
      exp_q    <= '0;
      for (int i = 0; i < SOURCES; i++) begin
        status_q[i] <= ST_NONE;
        timer_q[i]  <= '0;
      end
    end else if (adv) begin
      mode_q   <= mode_d;
      run_q    <= run_d;
      killed_q <= killed_d;
      pend_q   <= pend_d;
      val_q    <= val_d;
      exp_q    <= exp_d;
      for (int i = 0; i < SOURCES; i++) begin
        status_q[i] <= status_d[i];
        timer_q[i]  <= timer_d[i];
      end
    end
  end

  // only a pending source can hold a running timer
  always_comb begin
    timer_ok = 1'b1;
    for (int i = 0; i < SOURCES; i++) begin
      if (status_q[i] != ST_PENDING && timer_q[i] != '0) begin
        timer_ok = 1'b0;
      end
    end
  end

  `RRWVM_ASSERT(a_idle_timer_zero, timer_ok, "non-pending source with nonzero timer")
  `RRWVM_ASSERT_NEXT(a_shut_sticky, mode_q == MODE_SHUT, mode_q == MODE_SHUT, "left shutdown")
  `RRWVM_ASSERT_NEXT(a_adv_result, adv, out_vld_q, "processed event gave no result")
  `RRWVM_ASSERT_NEXT(a_killed_hold, !(adv && in_q.opcode == OP_KILL), $stable(killed_q),
                     "killed mask changed without kill-all")

endmodule
